// ----- rtl/rlpwe_pkg.sv -----
// ----------------------------------------------------------------------------
// rlpwe_pkg
// Shared types, constants and helper functions for the RGB LED
// pulse-width encoder.
// ----------------------------------------------------------------------------
package rlpwe_pkg;

   localparam int COLOR_W = 8;
   localparam int TICKS_W = 6;
   localparam int PROD_W = 2 * COLOR_W;
   localparam int PIXEL_BITS = 3 * COLOR_W;
   localparam int SLOT_CNT_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [COLOR_W-1:0] BRIGHTNESS_RST = 8'd64;
   localparam logic [TICKS_W-1:0] ZERO_TICKS_RST = 6'd19;
   localparam logic [TICKS_W-1:0] ONE_TICKS_RST = 6'd41;
   localparam logic [PROD_W:0] ROUND_BIAS = 17'd127;

   localparam logic [SLOT_CNT_W-1:0] SLOT_LEAD = 5'd0;
   localparam logic [SLOT_CNT_W-1:0] SLOT_FIRST_DATA = 5'd1;
   localparam logic [SLOT_CNT_W-1:0] SLOT_LAST_DATA = 5'd24;
   localparam logic [SLOT_CNT_W-1:0] SLOT_TRAIL = 5'd25;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_ZERO_TICKS = 2'd1,
      CSR_ONE_TICKS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  lead;
      logic                  last;
      logic [PIXEL_BITS-1:0] pattern;
   } entry_type;

   typedef struct packed {
      logic [TICKS_W-1:0] zero_ticks;
      logic [TICKS_W-1:0] one_ticks;
   } ticks_cfg_type;

   // Rounded division of a color product by 255, valid for products up to 255 * 255.
   function automatic logic [COLOR_W-1:0] div255_round(input logic [PROD_W-1:0] prod);
      logic [PROD_W:0] biased;
      logic [PROD_W:0] total;
      biased = {1'b0, prod} + ROUND_BIAS;
      total = biased + {{COLOR_W{1'b0}}, biased[PROD_W:COLOR_W]} + 17'd1;
      return total[PROD_W-1:COLOR_W];
   endfunction

endpackage

// ----- rtl/rlpwe_front.sv -----
// ----------------------------------------------------------------------------
// rlpwe_front
// Accepts pixel words, scales each color by the brightness and tags the
// entry with its frame-start and frame-end flags.
// ----------------------------------------------------------------------------
module rlpwe_front
   import rlpwe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COLOR_W-1:0]    brightness,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_BITS-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  push_valid,
   input  logic                  push_ready,
   output entry_type             push_entry
);

   logic              valid_ff, valid_in;
   logic              start_ff, start_in;
   logic              lead_ff, last_ff;
   logic [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic              take;

   assign req_tready = !valid_ff || push_ready;
   assign take = req_tvalid && req_tready;
   assign valid_in = take ? 1'b1 : (push_ready ? 1'b0 : valid_ff);
   assign start_in = take ? req_tlast : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         start_ff <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prod_r_ff <= req_tdata[COLOR_W-1:0] * brightness;
         prod_g_ff <= req_tdata[2*COLOR_W-1:COLOR_W] * brightness;
         prod_b_ff <= req_tdata[3*COLOR_W-1:2*COLOR_W] * brightness;
         lead_ff <= start_ff;
         last_ff <= req_tlast;
      end
   end

   assign push_valid = valid_ff;

   always_comb begin
      push_entry.lead = lead_ff;
      push_entry.last = last_ff;
      push_entry.pattern = {div255_round(prod_g_ff), div255_round(prod_r_ff),
                            div255_round(prod_b_ff)};
   end

endmodule

// ----- rtl/rlpwe_queue.sv -----
// ----------------------------------------------------------------------------
// rlpwe_queue
// Short first-in first-out queue of scaled pixels between the front and
// the slot sequencer.
// ----------------------------------------------------------------------------
module rlpwe_queue
   import rlpwe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_entry = store_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ((wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? ((rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/rlpwe_back.sv -----
// ----------------------------------------------------------------------------
// rlpwe_back
// Slot sequencer: walks one queued pixel through its leading, data and
// trailing slots and drives the registered result channel.
// ----------------------------------------------------------------------------
module rlpwe_back
   import rlpwe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ticks_cfg_type         ticks_cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  entry_type             pop_entry,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic                  busy_ff, busy_in;
   logic                  last_ff, last_in;
   logic [SLOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PIXEL_BITS-1:0] shift_ff, shift_in;
   logic                  out_valid_ff, out_valid_in;
   logic [TICKS_W-1:0]    out_ticks_ff;
   logic                  out_last_ff, out_end_ff;
   logic                  out_free, emit, load;
   logic                  is_lead, is_trail, finish;
   logic [TICKS_W-1:0]    ticks;

   assign is_lead = cnt_ff == SLOT_LEAD;
   assign is_trail = cnt_ff == SLOT_TRAIL;
   assign finish = is_trail || (cnt_ff == SLOT_LAST_DATA && !last_ff);
   assign ticks = (is_lead || is_trail || !shift_ff[PIXEL_BITS-1]) ?
                  ticks_cfg.zero_ticks : ticks_cfg.one_ticks;

   assign out_free = !out_valid_ff || rsp_tready;
   assign emit = busy_ff && out_free;
   assign pop_ready = !busy_ff || (out_free && finish);
   assign load = pop_valid && pop_ready;

   always_comb begin
      busy_in = busy_ff;
      last_in = last_ff;
      cnt_in = cnt_ff;
      shift_in = shift_ff;
      if (load) begin
         busy_in = 1'b1;
         last_in = pop_entry.last;
         cnt_in = pop_entry.lead ? SLOT_LEAD : SLOT_FIRST_DATA;
         shift_in = pop_entry.pattern;
      end else if (emit) begin
         busy_in = !finish;
         cnt_in = cnt_ff + 1'b1;
         if (!is_lead) begin
            shift_in = {shift_ff[PIXEL_BITS-2:0], 1'b0};
         end
      end
   end

   assign out_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      cnt_ff <= cnt_in;
      shift_ff <= shift_in;
      if (emit) begin
         out_ticks_ff <= ticks;
         out_last_ff <= finish;
         out_end_ff <= is_trail;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {2'b00, out_ticks_ff};
   assign rsp_tlast = out_last_ff;
   assign rsp_tuser = out_end_ff;

endmodule

// ----- rtl/rgb_led_pulse_width_encoder.sv -----
// ----------------------------------------------------------------------------
// rgb_led_pulse_width_encoder
// Turns RGB pixel words into a stream of LED pulse high-time codes.
// ----------------------------------------------------------------------------
// Each pixel word yields 24 slot words, green then red then blue, most
// significant bit first, plus a leading zero-code slot on the first pixel of
// a frame and a trailing slot (tuser high) after the pixel marked with tlast.
// The slot sequencer emits one slot word per cycle while rsp_tready is high;
// a pixel passes through the front register and the queue before the
// sequencer loads it and its first slot appears.
// Colors are scaled by brightness with rounding before encoding.
// ----------------------------------------------------------------------------
module rgb_led_pulse_width_encoder
   import rlpwe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_BITS-1:0]  req_tdata,   // red, green, blue
   input  logic                   req_tlast,   // last_pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // high_ticks, two zero bits
   output logic                   rsp_tlast,   // slot_last
   output logic                   rsp_tuser    // frame_end
);

   logic [COLOR_W-1:0] brightness_ff, brightness_in;
   logic [TICKS_W-1:0] zero_ticks_ff, zero_ticks_in;
   logic [TICKS_W-1:0] one_ticks_ff, one_ticks_in;
   ticks_cfg_type      ticks_cfg;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   entry_type          push_entry, pop_entry;

   always_comb begin
      brightness_in = brightness_ff;
      zero_ticks_in = zero_ticks_ff;
      one_ticks_in = one_ticks_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BRIGHTNESS: brightness_in = csr_wdata;
            CSR_ZERO_TICKS: zero_ticks_in = csr_wdata[TICKS_W-1:0];
            CSR_ONE_TICKS: one_ticks_in = csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RST;
         zero_ticks_ff <= ZERO_TICKS_RST;
         one_ticks_ff <= ONE_TICKS_RST;
      end else begin
         brightness_ff <= brightness_in;
         zero_ticks_ff <= zero_ticks_in;
         one_ticks_ff <= one_ticks_in;
      end
   end

   assign ticks_cfg.zero_ticks = zero_ticks_ff;
   assign ticks_cfg.one_ticks = one_ticks_ff;

   rlpwe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .brightness (brightness_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rlpwe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rlpwe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ticks_cfg  (ticks_cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/rlpwe_checker.sv -----
// ----------------------------------------------------------------------------
// rlpwe_checker
// Port-level checks for the RGB LED pulse-width encoder.
// ----------------------------------------------------------------------------
module rlpwe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result word valid right after reset.");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("Frame end word is not the last word of its pixel.");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] == 2'b00)
      else $error("Padding bits of the result word are not zero.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("Stalled result word changed.");

endmodule

bind rgb_led_pulse_width_encoder rlpwe_checker u_rlpwe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
